FILE: hdl/ookpw_pkg.sv
// Shared types and constants for the OOK pulse-width frame decoder.
package ookpw_pkg;

  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned SUM_W = WIDTH_W + 1;
  localparam int unsigned FRAME_W = 24;

  localparam logic [7:0] SAT_MAX = 8'd250;
  localparam logic [SUM_W:0] STEADY_TOL = 18'd120;
  localparam logic [4:0] SYNC_LO_MUL = 5'd28;
  localparam logic [5:0] SYNC_HI_MUL = 6'd37;
  localparam logic [1:0] NOISE_LO_MUL = 2'd2;
  localparam logic [2:0] NOISE_HI_MUL = 3'd6;
  localparam logic [1:0] BIT_LO_MUL = 2'd3;
  localparam logic [2:0] BIT_HI_MUL = 3'd5;
  localparam logic [1:0] LAST_BYTE = 2'd2;
  localparam logic [1:0] BAD_BYTE = 2'd3;

  localparam logic [15:0] RST_BASE_MIN = 16'd200;
  localparam logic [15:0] RST_BASE_MAX = 16'd1000;
  localparam logic [7:0] RST_BAD_LIMIT = 8'd3;
  localparam logic [7:0] RST_OK_LIMIT = 8'd3;

  typedef enum logic [1:0] {
    REG_BASE_MIN  = 2'd0,
    REG_BASE_MAX  = 2'd1,
    REG_BAD_LIMIT = 2'd2,
    REG_OK_LIMIT  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_OK    = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_FRAME = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_UPDATE,
    S_ROUTE,
    S_CLEAR,
    S_MAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic update;
    logic show_main;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic has_main;
  } dp_status_t;

endpackage

FILE: hdl/ook_pulse_width_frame_decoder.sv
// Top level of the OOK pulse-width frame decoder.
//
// Input channel: one word per RF pin edge (pin_level, width, first_edge),
// moved when in_valid is high and in_stall is low. Output channel: zero to
// two result words per edge (kind, frame_data, last), moved when out_valid
// is high and out_stall is low; last marks the final word of an edge.
// Configuration: cfg_write_en with cfg_index and cfg_data writes base_min,
// base_max, bad_limit or ok_limit; write only while the block is idle.
// Sequencing: one edge word is handled at a time by the controller sequence
// accept, evaluate, update, route. The result words follow in the clear
// and main states, and no new edge word is accepted until they are taken.
// A stalled result word holds its value, and in_stall stays high until the
// last word of the edge is taken. Synchronous reset returns the controller
// to idle, clears the decoder state to sync mode and loads the register
// defaults 200, 1000, 3 and 3.
module ook_pulse_width_frame_decoder
  import ookpw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               pin_level,
  input  logic [WIDTH_W-1:0] width,
  input  logic               first_edge,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [FRAME_W-1:0] frame_data,
  output logic               last
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  ookpw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ookpw_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pin_level    (pin_level),
    .width        (width),
    .first_edge   (first_edge),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .frame_data   (frame_data),
    .last         (last)
  );

endmodule

FILE: hdl/ookpw_ctrl.sv
// Controller state machine that sequences one edge word through the datapath.
module ookpw_ctrl
  import ookpw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_ROUTE;
      end
      S_ROUTE: begin
        priority if (sts.first) begin
          state_next = S_CLEAR;
        end else if (sts.has_main) begin
          state_next = S_MAIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = sts.has_main ? S_MAIN : S_IDLE;
        end
      end
      S_MAIN: begin
        out_valid = 1'b1;
        cmd.show_main = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EVAL))
    else $error("accepted word did not start evaluation");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (!out_valid ##1 !out_valid ##1 !out_valid))
    else $error("result shown before the update finished");

  a_main_needs_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAIN) |-> sts.has_main)
    else $error("main result shown without one pending");

  a_clear_needs_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> sts.first)
    else $error("clear command shown for a word that was not a first edge");
`endif

endmodule

FILE: hdl/ookpw_datapath.sv
// Datapath with configuration, decoder state, period checks and result registers.
module ookpw_datapath
  import ookpw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 pin_level,
  input  logic [WIDTH_W-1:0]   width,
  input  logic                 first_edge,
  input  dp_cmd_t              cmd,
  output dp_status_t           sts,
  output logic [1:0]           kind,
  output logic [FRAME_W-1:0]   frame_data,
  output logic                 last
);

  logic [15:0] base_min;
  logic [15:0] base_max;
  logic [7:0]  bad_limit;
  logic [7:0]  ok_limit;

  logic               cur_level;
  logic [WIDTH_W-1:0] cur_low;
  logic               cur_first;

  logic               in_data_mode;
  logic [WIDTH_W-1:0] high_width;
  logic [WIDTH_W-1:0] base_time;
  logic [2:0]         bit_phase;
  logic [1:0]         byte_index;
  logic [7:0]         bit_shift;
  logic [7:0]         frame_bytes [3];
  logic [7:0]         noise_count;
  logic [7:0]         steady_count;
  logic [SUM_W-1:0]   previous_period;

  logic             f_sync;
  logic             f_noise;
  logic             f_steady;
  logic             f_bit_ok;
  logic             f_bit_one;
  logic [SUM_W-1:0] sum_q;

  logic                has_main;
  kind_t               main_kind;
  logic [FRAME_W-1:0]  main_data;

  logic [SUM_W-1:0]   sum;
  logic [WIDTH_W-1:0] min_hl;
  logic [20:0]        h_lo;
  logic [21:0]        h_hi;
  logic [17:0]        m_lo;
  logic [18:0]        m_hi;
  logic [17:0]        b_lo;
  logic [18:0]        b_hi;
  logic               sync_ok;
  logic               noise;
  logic               steady;

  logic [7:0] noise_inc;
  logic [7:0] steady_inc;
  logic [7:0] shift_next;
  logic [2:0] phase_next;
  logic [1:0] byte_slot;

  always_comb begin
    sum = {1'b0, high_width} + {1'b0, cur_low};
    min_hl = (high_width > cur_low) ? cur_low : high_width;
    h_lo = 21'(high_width) * 21'(SYNC_LO_MUL);
    h_hi = 22'(high_width) * 22'(SYNC_HI_MUL);
    m_lo = 18'(min_hl) * 18'(NOISE_LO_MUL);
    m_hi = 19'(min_hl) * 19'(NOISE_HI_MUL);
    b_lo = 18'(base_time) * 18'(BIT_LO_MUL);
    b_hi = 19'(base_time) * 19'(BIT_HI_MUL);
    sync_ok = (high_width != '0) && (high_width >= base_min) && (high_width <= base_max)
              && (21'(cur_low) >= h_lo) && (22'(cur_low) < h_hi);
    noise = (high_width < base_min) || (min_hl == '0)
            || (18'(sum) < m_lo) || (19'(sum) >= m_hi);
    steady = (18'(sum) <= 18'(previous_period) + STEADY_TOL)
             && (18'(sum) + STEADY_TOL >= 18'(previous_period));
  end

  always_comb begin
    noise_inc = (noise_count < SAT_MAX) ? noise_count + 8'd1 : noise_count;
    steady_inc = (steady_count < SAT_MAX) ? steady_count + 8'd1 : steady_count;
    shift_next = {bit_shift[6:0], f_bit_ok & f_bit_one};
    phase_next = bit_phase + 3'd1;
    byte_slot = (byte_index == BAD_BYTE) ? 2'd0 : byte_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_min <= RST_BASE_MIN;
      base_max <= RST_BASE_MAX;
      bad_limit <= RST_BAD_LIMIT;
      ok_limit <= RST_OK_LIMIT;
    end else if (cfg_write_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_BASE_MIN:  base_min <= cfg_data;
        REG_BASE_MAX:  base_max <= cfg_data;
        REG_BAD_LIMIT: bad_limit <= cfg_data[7:0];
        REG_OK_LIMIT:  ok_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_level <= pin_level;
      cur_low <= width;
      cur_first <= first_edge;
    end
    if (cmd.eval) begin
      f_sync <= sync_ok;
      f_noise <= noise;
      f_steady <= steady;
      f_bit_ok <= (18'(sum) >= b_lo) && (19'(sum) <= b_hi);
      f_bit_one <= (cur_low <= high_width);
      sum_q <= sum;
    end
    if (cmd.update && cur_level && in_data_mode && f_bit_ok && (phase_next == 3'd0)) begin
      frame_bytes[byte_slot] <= shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_data_mode <= 1'b0;
      high_width <= '0;
      base_time <= '0;
      bit_phase <= '0;
      byte_index <= '0;
      bit_shift <= '0;
      noise_count <= '0;
      steady_count <= '0;
      previous_period <= '0;
      has_main <= 1'b0;
      main_kind <= KIND_OK;
      main_data <= '0;
    end else begin
      if (cmd.eval && cur_first) begin
        noise_count <= '0;
        steady_count <= '0;
      end
      if (cmd.update) begin
        has_main <= 1'b0;
        main_kind <= KIND_OK;
        main_data <= '0;
        if (!cur_level) begin
          high_width <= cur_low;
        end else if (!in_data_mode) begin
          priority if (f_sync) begin
            base_time <= high_width;
            bit_phase <= '0;
            byte_index <= '0;
            noise_count <= '0;
            steady_count <= '0;
            previous_period <= '0;
            in_data_mode <= 1'b1;
            has_main <= 1'b1;
          end else if (f_noise) begin
            noise_count <= noise_inc;
            steady_count <= '0;
            previous_period <= '0;
            has_main <= (noise_inc >= bad_limit);
            main_kind <= KIND_BAD;
          end else begin
            if (f_steady) begin
              if (steady_inc >= ok_limit) begin
                noise_count <= '0;
                steady_count <= '0;
                has_main <= 1'b1;
              end else begin
                steady_count <= steady_inc;
              end
            end
            previous_period <= sum_q;
          end
        end else begin
          bit_shift <= shift_next;
          if (f_bit_ok) begin
            bit_phase <= phase_next;
            if (phase_next == 3'd0) begin
              byte_index <= byte_index + 2'd1;
              if (byte_index == LAST_BYTE) begin
                has_main <= 1'b1;
                main_kind <= KIND_FRAME;
                main_data <= {frame_bytes[0], frame_bytes[1], shift_next};
                in_data_mode <= 1'b0;
              end
            end
          end else begin
            in_data_mode <= 1'b0;
          end
        end
      end
    end
  end

  assign sts.first = cur_first;
  assign sts.has_main = has_main;

  always_comb begin
    if (cmd.show_main) begin
      kind = main_kind;
      frame_data = main_data;
      last = 1'b1;
    end else begin
      kind = KIND_CLEAR;
      frame_data = '0;
      last = !has_main;
    end
  end

endmodule
